// ===== src/imfe_pkg.sv =====
// Shared constants and codes for the Ising Metropolis flip engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imfe_pkg;

    localparam int DEF_MAX_SIDE = 64;

    // Lehmer generator, modulus 2^31-1
    localparam logic [14:0] LEH_A      = 15'd16807;
    localparam logic [30:0] LEH_M      = 31'h7FFF_FFFF;
    localparam logic [31:0] LEH_MASK   = 32'd123459876;
    localparam logic [30:0] HALF_LIMIT = 31'd1073741823;

    localparam logic [31:0] SEED_RESET = 32'hFFFF_FFFF;
    localparam logic [6:0]  SIDE_RESET = 7'd64;
    localparam logic [30:0] THR_RESET  = 31'h7FFF_FFFF;
    localparam int          THR_N      = 5;

    // Configuration register indexes
    localparam logic [2:0] CFG_SIDE   = 3'd0;
    localparam logic [2:0] CFG_SEED   = 3'd1;
    localparam logic [2:0] CFG_THR_M4 = 3'd2;
    localparam logic [2:0] CFG_THR_M2 = 3'd3;
    localparam logic [2:0] CFG_THR_Z  = 3'd4;
    localparam logic [2:0] CFG_THR_P2 = 3'd5;
    localparam logic [2:0] CFG_THR_P4 = 3'd6;

    // Command modes
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_TRIAL = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

endpackage

`default_nettype wire

// ===== src/imfe_mul_unit.sv =====
// Shared multiplier with Mersenne fold: mod 2^31-1 and floor(P/(2^31-1)).
// Depends on imfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imfe_mul_unit
    import imfe_pkg::*;
#(
    parameter int MW = 15
)(
    input  logic          clk,
    input  logic          load,
    input  logic [30:0]   op_a,
    input  logic [MW-1:0] op_b,
    output logic [30:0]   mod_res,
    output logic [MW-1:0] scale_res
);

    logic [30+MW:0] prod_reg;
    logic [MW-1:0]  hi;
    logic [31:0]    fold;
    logic           carry;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= (31+MW)'(op_a) * (31+MW)'(op_b);
        end
    end

    // P = hi*2^31 + lo = hi*M + (hi + lo)
    assign hi        = prod_reg[30+MW:31];
    assign fold      = 32'(prod_reg[30:0]) + 32'(hi);
    assign carry     = (fold >= 32'(LEH_M));
    assign mod_res   = carry ? 31'(fold - 32'(LEH_M)) : fold[30:0];
    assign scale_res = hi + MW'(carry);

endmodule

`default_nettype wire

// ===== src/imfe_spin_ram.sv =====
// One-bit spin memory with a clearing pass after reset.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module imfe_spin_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)(
    input  logic          clk,
    input  logic          rst_n,
    output logic          ready,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data
);

    logic          mem [DEPTH];
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign ready   = !clr_active_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/ising_metropolis_flip_engine.sv =====
// Ising lattice Metropolis engine: sequencer, config registers, spin store.
// Depends on imfe_pkg, imfe_mul_unit, imfe_spin_ram.
//
// Usage:
//  Command channel: a command is taken when start is high and busy low.
//  Config channel: cfg_valid/cfg_ready (ready always high), cfg_index
//  selects the register, cfg_data the value; write only while idle.
//  A seed write reloads the generator at once.
//  Each command gives one result beat, shown for one cycle with
//  result_valid; there is no back-pressure on results.
//  A bad coordinate beat is registered straight from idle without busy;
//  otherwise busy stays high until the beat, so one command is in
//  flight at a time. The generator steps and side scaling all go through
//  one shared 31 x 15 bit multiplier (multiply, then fold): a draw passes
//  PREP, MUL and RED, a scale SMUL and SRED; the five lattice reads share
//  one RAM port. After reset the spin store is cleared one site per cycle
//  (MAX_SIDE*MAX_SIDE sites, 4096 by default) with busy high; config
//  writes are taken during that time.
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_flip_engine
    import imfe_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        mode,
    input  logic [5:0]        coord_x,
    input  logic [5:0]        coord_y,
    output logic              result_valid,
    output logic [5:0]        site_x,
    output logic [5:0]        site_y,
    output logic              spin_up,
    output logic              flipped,
    output logic signed [3:0] local_sum,
    output logic              bad_coordinate,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int EW    = (SW > 7) ? SW : 7;
    localparam int PW    = (SW > 6) ? SW : 6;
    localparam int MW    = (SW > 15) ? SW : 15;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] NB_CENTRE = 3'd0;
    localparam logic [2:0] NB_XM     = 3'd1;
    localparam logic [2:0] NB_XP     = 3'd2;
    localparam logic [2:0] NB_YM     = 3'd3;
    localparam logic [2:0] NB_YP     = 3'd4;
    localparam logic [2:0] NB_END    = 3'd5;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_PREP  = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_RED   = 9'b000010000,
        ST_SMUL  = 9'b000100000,
        ST_SRED  = 9'b001000000,
        ST_NBR   = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        DR_INIT,
        DR_X,
        DR_Y,
        DR_A
    } draw_t;

    state_t        state_reg, state_next;
    draw_t         draw_sel_reg;
    logic [1:0]    mode_reg;
    logic [CW-1:0] cx_reg, cy_reg;
    logic [30:0]   u_reg, u_next;
    logic [30:0]   r_reg;
    logic [31:0]   rng_reg;
    logic [2:0]    nb_cnt_reg;
    logic          s_up_reg;
    logic [2:0]    ups_reg;
    logic [6:0]    side_reg;
    logic [30:0]   thr_reg [THR_N];
    logic          result_valid_reg;
    logic [5:0]    site_x_reg, site_y_reg;
    logic          spin_up_reg, flipped_reg, bad_reg;
    logic [3:0]    ls_reg;

    logic [EW-1:0] side_w;
    logic [SW-1:0] side_eff;
    logic [PW-1:0] in_x_w, in_y_w, cx_w, cy_w;
    logic          in_bad;
    logic [CW-1:0] xm, xp, ym, yp;
    logic [AW-1:0] rd_addr, centre_addr;
    logic          rd_data, ram_ready, ram_we, ram_wdata;
    logic [30:0]   mod_res;
    logic [MW-1:0] scale_res;
    logic [MW-1:0] mul_b;
    logic [30:0]   mul_a;
    logic          mul_load;
    logic [31:0]   s_raw;
    logic [3:0]    sum_nb, ls_val;
    logic [2:0]    thr_idx;
    logic          accept, half_up;

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y);
        return AW'(x) * AW'(MAX_SIDE) + AW'(y);
    endfunction

    // effective side: 0 acts as 1, clamp to MAX_SIDE
    assign side_w = EW'(side_reg);
    always_comb
    begin
        if (side_w == '0)
        begin
            side_eff = SW'(1);
        end
        else if (side_w > EW'(MAX_SIDE))
        begin
            side_eff = SW'(MAX_SIDE);
        end
        else
        begin
            side_eff = SW'(side_w);
        end
    end

    assign in_x_w = PW'(coord_x);
    assign in_y_w = PW'(coord_y);
    assign in_bad = (in_x_w >= PW'(side_eff)) || (in_y_w >= PW'(side_eff));
    assign cx_w   = PW'(cx_reg);
    assign cy_w   = PW'(cy_reg);

    // periodic neighbours
    assign xm = (cx_reg == '0) ? CW'(side_eff - 1'b1) : cx_reg - 1'b1;
    assign xp = (SW'(cx_reg) == side_eff - 1'b1) ? '0 : cx_reg + 1'b1;
    assign ym = (cy_reg == '0) ? CW'(side_eff - 1'b1) : cy_reg - 1'b1;
    assign yp = (SW'(cy_reg) == side_eff - 1'b1) ? '0 : cy_reg + 1'b1;

    assign centre_addr = site_addr(cx_reg, cy_reg);
    always_comb
    begin
        case (nb_cnt_reg)
            NB_XM:   rd_addr = site_addr(xm, cy_reg);
            NB_XP:   rd_addr = site_addr(xp, cy_reg);
            NB_YM:   rd_addr = site_addr(cx_reg, ym);
            NB_YP:   rd_addr = site_addr(cx_reg, yp);
            default: rd_addr = centre_addr;
        endcase
    end

    // signed generator state reduced mod 2^31-1
    assign s_raw = rng_reg ^ LEH_MASK;
    always_comb
    begin
        if (!s_raw[31])
        begin
            u_next = (s_raw[30:0] == LEH_M) ? '0 : s_raw[30:0];
        end
        else if (s_raw == 32'h8000_0000)
        begin
            u_next = LEH_M - 1'b1;
        end
        else
        begin
            u_next = 31'(s_raw + 32'(LEH_M));
        end
    end

    assign mul_load = (state_reg == ST_MUL) || (state_reg == ST_SMUL);
    assign mul_a    = (state_reg == ST_SMUL) ? r_reg : u_reg;
    assign mul_b    = (state_reg == ST_SMUL) ? MW'(side_eff) : MW'(LEH_A);

    imfe_mul_unit #(
        .MW(MW)
    ) u_mul (
        .clk      (clk),
        .load     (mul_load),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .mod_res  (mod_res),
        .scale_res(scale_res)
    );

    // spin * neighbour sum, and threshold select (ls+4)/2
    assign sum_nb  = 4'({ups_reg, 1'b0}) - 4'd4;
    assign ls_val  = s_up_reg ? sum_nb : 4'd0 - sum_nb;
    assign thr_idx = s_up_reg ? ups_reg : 3'd4 - ups_reg;
    assign accept  = (r_reg <= thr_reg[thr_idx]);
    assign half_up = (r_reg <= HALF_LIMIT);

    assign ram_we    = (state_reg == ST_FIN)
                       && ((mode_reg == MODE_INIT) || ((mode_reg == MODE_TRIAL) && accept));
    assign ram_wdata = (mode_reg == MODE_INIT) ? half_up : !s_up_reg;

    imfe_spin_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .ready  (ram_ready),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .we     (ram_we),
        .wr_addr(centre_addr),
        .wr_data(ram_wdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (ram_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_TRIAL || mode == MODE_INIT)
                    begin
                        if (mode == MODE_TRIAL || !in_bad)
                        begin
                            state_next = ST_PREP;
                        end
                    end
                    else if (!in_bad)
                    begin
                        state_next = ST_NBR;
                    end
                end
            end
            ST_PREP: state_next = ST_MUL;
            ST_MUL:  state_next = ST_RED;
            ST_RED:
            begin
                if (draw_sel_reg == DR_X || draw_sel_reg == DR_Y)
                begin
                    state_next = ST_SMUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SMUL: state_next = ST_SRED;
            ST_SRED: state_next = (draw_sel_reg == DR_X) ? ST_PREP : ST_NBR;
            ST_NBR:
            begin
                if (mode_reg == MODE_TRIAL)
                begin
                    if (nb_cnt_reg == NB_END)
                    begin
                        state_next = ST_PREP;
                    end
                end
                else if (nb_cnt_reg == NB_XM)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            result_valid_reg <= 1'b0;
            rng_reg          <= SEED_RESET;
            side_reg         <= SIDE_RESET;
            for (int i = 0; i < THR_N; i++)
            begin
                thr_reg[i] <= THR_RESET;
            end
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == ST_FIN)
                                || ((state_reg == ST_IDLE) && start
                                    && (mode != MODE_TRIAL) && in_bad);
            if (state_reg == ST_RED)
            begin
                rng_reg <= 32'(mod_res) ^ LEH_MASK;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index) inside
                    CFG_SIDE: side_reg <= cfg_data[6:0];
                    CFG_SEED: rng_reg  <= cfg_data;
                    CFG_THR_M4, CFG_THR_M2, CFG_THR_Z, CFG_THR_P2, CFG_THR_P4:
                        thr_reg[3'(cfg_index - CFG_THR_M4)] <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            mode_reg     <= mode;
            cx_reg       <= in_x_w[CW-1:0];
            cy_reg       <= in_y_w[CW-1:0];
            nb_cnt_reg   <= NB_CENTRE;
            draw_sel_reg <= (mode == MODE_TRIAL) ? DR_X : DR_INIT;
            if (mode != MODE_TRIAL && in_bad)
            begin
                site_x_reg  <= coord_x;
                site_y_reg  <= coord_y;
                spin_up_reg <= 1'b0;
                flipped_reg <= 1'b0;
                ls_reg      <= '0;
                bad_reg     <= 1'b1;
            end
        end
        if (state_reg == ST_PREP)
        begin
            u_reg <= u_next;
        end
        if (state_reg == ST_RED)
        begin
            r_reg <= mod_res;
        end
        if (state_reg == ST_SRED)
        begin
            if (draw_sel_reg == DR_X)
            begin
                cx_reg       <= scale_res[CW-1:0];
                draw_sel_reg <= DR_Y;
            end
            else
            begin
                cy_reg       <= scale_res[CW-1:0];
                draw_sel_reg <= DR_A;
                nb_cnt_reg   <= NB_CENTRE;
            end
        end
        if (state_reg == ST_NBR)
        begin
            nb_cnt_reg <= nb_cnt_reg + 1'b1;
            if (nb_cnt_reg == NB_XM)
            begin
                s_up_reg <= rd_data;
                ups_reg  <= '0;
            end
            else if (nb_cnt_reg != NB_CENTRE)
            begin
                ups_reg <= ups_reg + 3'(rd_data);
            end
        end
        if (state_reg == ST_FIN)
        begin
            site_x_reg <= cx_w[5:0];
            site_y_reg <= cy_w[5:0];
            bad_reg    <= 1'b0;
            unique case (mode_reg) inside
                MODE_INIT:
                begin
                    spin_up_reg <= half_up;
                    flipped_reg <= 1'b0;
                    ls_reg      <= '0;
                end
                MODE_TRIAL:
                begin
                    spin_up_reg <= s_up_reg ^ accept;
                    flipped_reg <= accept;
                    ls_reg      <= ls_val;
                end
                default:
                begin
                    spin_up_reg <= s_up_reg;
                    flipped_reg <= 1'b0;
                    ls_reg      <= '0;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign result_valid   = result_valid_reg;
    assign site_x         = site_x_reg;
    assign site_y         = site_y_reg;
    assign spin_up        = spin_up_reg;
    assign flipped        = flipped_reg;
    assign local_sum      = $signed(ls_reg);
    assign bad_coordinate = bad_reg;

    a_beat_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while busy");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bad_coordinate) |-> (!flipped && !spin_up && local_sum == 4'sd0))
        else $error("bad coordinate beat carries site data");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (result_valid || busy))
        else $error("accepted command dropped");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for ising_metropolis_flip_engine: a clocked driver and
// monitor around an in-bench lattice and Lehmer generator model.
// Depends on imfe_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
    import imfe_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         LIMIT_CYC  = 400000;
    localparam int         SETTLE_CYC = 30;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] x;
        logic [5:0] y;
    } cmd_t;

    typedef struct packed {
        logic [5:0]        site_x;
        logic [5:0]        site_y;
        logic              spin_up;
        logic              flipped;
        logic signed [3:0] local_sum;
        logic              bad;
    } site_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] mode = '0;
    logic [5:0] coord_x = '0;
    logic [5:0] coord_y = '0;
    logic cfg_valid = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic busy, result_valid, spin_up, flipped, bad_coordinate, cfg_ready;
    logic [5:0] site_x, site_y;
    logic signed [3:0] local_sum;

    ising_metropolis_flip_engine dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .coord_x(coord_x), .coord_y(coord_y), .result_valid(result_valid),
        .site_x(site_x), .site_y(site_y), .spin_up(spin_up), .flipped(flipped),
        .local_sum(local_sum), .bad_coordinate(bad_coordinate),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // lattice model
    logic        lattice [0:4095];
    logic [31:0] gen_state = SEED_RESET;
    logic [6:0]  side_reg = SIDE_RESET;
    logic [30:0] thr_reg [0:THR_N-1];

    cmd_t      pending_cmds [$];
    site_res_t expected_sites [$];
    bit        no_idle = 1'b0;
    int        gap = 0;
    int        cycles = 0;
    int        errors = 0;
    int        n_results = 0;
    int        n_flips = 0;
    int        n_bad = 0;
    int        n_trials = 0;

    initial begin
        for (int i = 0; i < 4096; i++)
            lattice[i] = 1'b0;
        for (int i = 0; i < THR_N; i++)
            thr_reg[i] = THR_RESET;
    end

    function automatic logic [30:0] lehmer_draw();
        longint s, k, v;
        s = longint'($signed(gen_state ^ LEH_MASK));
        k = s / 127773;
        v = 16807 * (s - k * 127773) - 2836 * k;
        if (v < 0)
            v += 2147483647;
        gen_state = 32'(v) ^ LEH_MASK;
        return 31'(v);
    endfunction

    function automatic int eff_side();
        if (side_reg == 0)
            return 1;
        if (side_reg > 64)
            return 64;
        return side_reg;
    endfunction

    function automatic int scale_side(int side, logic [30:0] r);
        longint v;
        v = (longint'(side) * longint'(r)) / 2147483647;
        return (v < side) ? int'(v) : side - 1;
    endfunction

    function automatic int spin_val(int x, int y);
        return lattice[x * 64 + y] ? 1 : -1;
    endfunction

    function automatic site_res_t predict_site(cmd_t c);
        site_res_t r;
        int side, x, y, s, nsum, ls;
        r = '0;
        side = eff_side();
        x = c.x;
        y = c.y;
        if (c.mode == MODE_TRIAL) begin
            x = scale_side(side, lehmer_draw());
            y = scale_side(side, lehmer_draw());
            s = spin_val(x, y);
            nsum = spin_val((x + side - 1) % side, y) + spin_val((x + 1) % side, y)
                 + spin_val(x, (y + side - 1) % side) + spin_val(x, (y + 1) % side);
            ls = s * nsum;
            r.local_sum = 4'(ls);
            if (lehmer_draw() <= thr_reg[(ls + 4) / 2]) begin
                s = -s;
                lattice[x * 64 + y] = (s > 0);
                r.flipped = 1'b1;
            end
            r.spin_up = (s > 0);
        end else if (x >= side || y >= side) begin
            r.bad = 1'b1;
        end else if (c.mode == MODE_INIT) begin
            r.spin_up = (lehmer_draw() <= HALF_LIMIT);
            lattice[x * 64 + y] = r.spin_up;
        end else begin
            r.spin_up = lattice[x * 64 + y];
        end
        r.site_x = 6'(x);
        r.site_y = 6'(y);
        return r;
    endfunction

    // command driver
    always @(posedge clk) begin
        cmd_t c;
        logic nstart;
        logic taken;
        taken = rst_n && start && !busy;
        nstart = start;
        if (taken) begin
            expected_sites.push_back(predict_site('{mode, coord_x, coord_y}));
            gap = no_idle ? 0 : $urandom_range(0, 3);
        end
        if (!start || taken) begin
            if (gap > 0) begin
                gap--;
                nstart = 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                mode <= c.mode;
                coord_x <= c.x;
                coord_y <= c.y;
                nstart = 1'b1;
            end else begin
                nstart = 1'b0;
            end
        end
        start <= nstart;
    end

    // result monitor
    always @(posedge clk) begin
        site_res_t got, want;
        if (rst_n && result_valid) begin
            got = '{site_x, site_y, spin_up, flipped, local_sum, bad_coordinate};
            n_results++;
            n_flips += flipped;
            n_bad += bad_coordinate;
            if (expected_sites.size() == 0) begin
                $display("%0t: unexpected result beat x=%0d y=%0d", $time, site_x, site_y);
                errors++;
            end else begin
                want = expected_sites.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch exp x=%0d y=%0d up=%0b fl=%0b ls=%0d bad=%0b",
                             $time, want.site_x, want.site_y, want.spin_up, want.flipped,
                             want.local_sum, want.bad);
                    $display("%0t:          got x=%0d y=%0d up=%0b fl=%0b ls=%0d bad=%0b",
                             $time, got.site_x, got.site_y, got.spin_up, got.flipped,
                             got.local_sum, got.bad);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_sites.size());
            $display("** ising_metropolis_flip_engine: FAILED **");
            $finish;
        end
    end

    task automatic push_cmd(logic [1:0] m, logic [5:0] x, logic [5:0] y);
        if (m == MODE_TRIAL)
            n_trials++;
        pending_cmds.push_back('{m, x, y});
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SIDE: side_reg = val[6:0];
            CFG_SEED: gen_state = val;
            default:  thr_reg[idx - CFG_THR_M4] = val[30:0];
        endcase
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || start || busy || expected_sites.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_thr();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    task automatic random_phase(logic [6:0] side, logic [31:0] seed_val, int count);
        int pick;
        cfg_write(CFG_SIDE, {25'd0, side});
        cfg_write(CFG_SEED, seed_val);
        cfg_write(CFG_THR_M4, pick_thr());
        cfg_write(CFG_THR_M2, pick_thr());
        cfg_write(CFG_THR_Z, pick_thr());
        cfg_write(CFG_THR_P2, pick_thr());
        cfg_write(CFG_THR_P4, pick_thr());
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_cmd(MODE_TRIAL, 6'($urandom), 6'($urandom));
            else if (pick < 70)
                push_cmd(MODE_INIT, 6'($urandom), 6'($urandom));
            else if (pick < 95)
                push_cmd(MODE_READ, 6'($urandom), 6'($urandom));
            else
                push_cmd(MODE_SPARE, 6'($urandom), 6'($urandom));
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, full lattice
        push_cmd(MODE_INIT, 6'd0, 6'd0);
        push_cmd(MODE_INIT, 6'd63, 6'd63);
        push_cmd(MODE_INIT, 6'd0, 6'd63);
        push_cmd(MODE_INIT, 6'd63, 6'd0);
        push_cmd(MODE_READ, 6'd0, 6'd0);
        push_cmd(MODE_READ, 6'd63, 6'd63);
        push_cmd(MODE_SPARE, 6'd42, 6'd21);
        push_cmd(MODE_TRIAL, 6'd0, 6'd0);
        push_cmd(MODE_TRIAL, 6'd63, 6'd63);
        push_cmd(MODE_TRIAL, 6'd0, 6'd0);
        drain();

        // one-site lattice: every neighbour is the site itself
        cfg_write(CFG_SIDE, 32'd1);
        cfg_write(CFG_THR_P4, 32'd0);
        push_cmd(MODE_INIT, 6'd0, 6'd0);
        push_cmd(MODE_INIT, 6'd1, 6'd0);
        push_cmd(MODE_READ, 6'd0, 6'd63);
        push_cmd(MODE_SPARE, 6'd63, 6'd63);
        push_cmd(MODE_TRIAL, 6'd5, 6'd9);
        push_cmd(MODE_READ, 6'd0, 6'd0);
        drain();

        // side 0 acts as 1, 127 acts as the maximum
        cfg_write(CFG_SIDE, 32'd0);
        cfg_write(CFG_SEED, 32'h8000_0000);
        push_cmd(MODE_INIT, 6'd0, 6'd1);
        push_cmd(MODE_TRIAL, 6'd0, 6'd0);
        drain();
        cfg_write(CFG_SIDE, 32'd127);
        cfg_write(CFG_SEED, 32'h7FFF_FFFF);
        push_cmd(MODE_INIT, 6'd63, 6'd62);
        push_cmd(MODE_TRIAL, 6'd0, 6'd0);
        push_cmd(MODE_READ, 6'd63, 6'd62);
        drain();

        random_phase(7'd2, 32'd0, 60);
        random_phase(7'd64, $urandom, 80);
        random_phase(7'd3, $urandom, 60);
        random_phase(7'($urandom_range(4, 8)), $urandom, 100);
        random_phase(7'($urandom_range(1, 64)), 32'hFFFF_FFFF, 100);
        random_phase(7'd4, $urandom, 100);

        $display("Ran %0d commands (%0d trials), %0d flips and %0d bad-coordinate beats",
                 n_results, n_trials, n_flips, n_bad);
        $display("over side settings 0, 1, 2, 3, 64, 127 and random seeds and thresholds.");
        if (errors == 0)
            $display("** ising_metropolis_flip_engine: PASSED **");
        else
            $display("** ising_metropolis_flip_engine: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
src/imfe_pkg.sv
src/imfe_mul_unit.sv
src/imfe_spin_ram.sv
src/ising_metropolis_flip_engine.sv
bench/testbench.sv
